// ----- rtl/core/pointer_motion_accelerator_macros.svh -----
// Assertion helpers for the checker of the pointer motion block.
// Every property is sampled on the rising edge of clk and is disabled
// while rst_n is low.
`ifndef POINTER_MOTION_ACCELERATOR_MACROS_SVH
`define POINTER_MOTION_ACCELERATOR_MACROS_SVH

// Same-cycle implication.
`define PMA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PMA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pma_pkg.sv -----
`default_nettype none

package pma_pkg;

    // Acceleration curve selector.
    typedef enum logic [1:0] {
        ACCEL_OFF  = 2'd0,
        ACCEL_LOW  = 2'd1,
        ACCEL_MED  = 2'd2,
        ACCEL_HIGH = 2'd3
    } accel_t;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LEVEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LEVEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_WINDOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_LOCK   = 3'd5;
    localparam int unsigned CFG_DATA_W = 16;

    // Field widths.
    localparam int unsigned SIZE_W   = 14;
    localparam int unsigned PIX_W    = 13;
    localparam int unsigned DELTA_W  = 16;
    localparam int unsigned SET_W    = 15;
    localparam int unsigned BTN_W    = 8;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned WINDOW_W = 16;
    localparam int unsigned S_TDATA_W = 104;
    localparam int unsigned M_TDATA_W = 40;

    // Screen limits and reset values.
    localparam int unsigned MAX_SCREEN     = 8192;
    localparam int unsigned RESET_WIDTH    = 1920;
    localparam int unsigned RESET_HEIGHT   = 1080;
    localparam int unsigned RESET_SPEED    = 5;
    localparam int unsigned RESET_WINDOW   = 400;

    // Speed multipliers in hundredths, level 1 through 10.
    localparam int unsigned SPEED_LEVELS = 10;
    localparam int unsigned SPEED_IDX_W  = 4;
    localparam int unsigned SPEED_HUNDREDTHS [SPEED_LEVELS] =
        '{25, 45, 65, 85, 100, 140, 180, 250, 320, 400};

    // Per-lane stage strobes issued by the sequencer.
    typedef struct packed {
        logic load;
        logic curve;
        logic scale;
    } lane_ctl_t;

    // Control into the merge stage.
    typedef struct packed {
        logic commit;
        logic op_set;
        logic lock;
    } merge_ctl_t;

    // Per-item flags produced by the merge stage.
    typedef struct packed {
        logic [BTN_W-1:0] held_buttons;
        logic             left_pressed;
        logic             double_click;
        logic             was_ignored;
    } merge_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/pma_lane.sv -----
`default_nettype none

// One axis: clamp and fold the delta, bend it through the curve, scale it by
// the speed multiplier, then advance and clamp the position.
module pma_lane #(
    parameter int FRAC_BITS   = 8,
    parameter int DELTA_LIMIT = 50
) (
    input  wire logic                                  clk,
    input  wire pma_pkg::lane_ctl_t                    ctl,
    input  wire logic signed [pma_pkg::DELTA_W-1:0]    delta,
    input  wire pma_pkg::accel_t                       accel,
    input  wire logic        [FRAC_BITS+2:0]           speed_q,
    input  wire logic        [pma_pkg::PIX_W+FRAC_BITS-1:0] pos,
    input  wire logic        [pma_pkg::SIZE_W-1:0]     size,
    input  wire logic signed [pma_pkg::SET_W-1:0]      set_v,
    output logic             [pma_pkg::PIX_W+FRAC_BITS-1:0] pos_moved,
    output logic             [pma_pkg::PIX_W+FRAC_BITS-1:0] pos_set
);

    localparam int A_W     = $clog2(DELTA_LIMIT + 1);
    localparam int M_W     = (A_W > 3) ? A_W : 3;
    localparam int OFF_W   = M_W + FRAC_BITS;
    localparam int K_W     = FRAC_BITS + 2;
    localparam int PROD_W  = OFF_W + K_W;
    localparam int Q_W     = OFF_W + 2;
    localparam int SPEED_W = FRAC_BITS + 3;
    localparam int P2_W    = Q_W + SPEED_W;
    localparam int MAG_W   = Q_W + 3;
    localparam int POS_W   = pma_pkg::PIX_W + FRAC_BITS;
    localparam int SUM_W   = ((POS_W > MAG_W) ? POS_W : MAG_W) + 2;
    localparam int SQ_W    = pma_pkg::SIZE_W + FRAC_BITS;
    localparam int unsigned HALF_I = 1 << (FRAC_BITS - 1);

    localparam logic [K_W-1:0] K_ONE = K_W'(1 << FRAC_BITS);
    localparam logic [K_W-1:0] K_12  = K_W'(((12 << FRAC_BITS) + 5) / 10);
    localparam logic [K_W-1:0] K_13  = K_W'(((13 << FRAC_BITS) + 5) / 10);
    localparam logic [K_W-1:0] K_14  = K_W'(((14 << FRAC_BITS) + 5) / 10);
    localparam logic [K_W-1:0] K_18  = K_W'(((18 << FRAC_BITS) + 5) / 10);
    localparam logic [K_W-1:0] K_20  = K_W'(2 << FRAC_BITS);
    localparam logic [K_W-1:0] K_30  = K_W'(3 << FRAC_BITS);

    localparam logic [OFF_W-1:0] B_ZERO     = '0;
    localparam logic [OFF_W-1:0] B_ONE_HALF = OFF_W'(3 << (FRAC_BITS - 1));
    localparam logic [OFF_W-1:0] B_TWO      = OFF_W'(2 << FRAC_BITS);
    localparam logic [OFF_W-1:0] B_THREE    = OFF_W'(3 << FRAC_BITS);
    localparam logic [OFF_W-1:0] B_FIVE     = OFF_W'(5 << FRAC_BITS);

    localparam logic signed [pma_pkg::DELTA_W-1:0] LIM_S = pma_pkg::DELTA_W'(DELTA_LIMIT);

    logic [A_W-1:0]   a_reg;
    logic             neg_reg;
    logic [Q_W-1:0]   q_reg;
    logic [MAG_W-1:0] mag_reg;

    logic [A_W-1:0]   a_next;
    logic [M_W-1:0]   a_m;
    logic [OFF_W-1:0] a_q;
    logic [OFF_W-1:0] base;
    logic [K_W-1:0]   k;
    logic [OFF_W-1:0] off;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] rnd;
    logic [P2_W-1:0]  prod2;
    logic [P2_W-1:0]  rnd2;
    logic [SUM_W-1:0] pos_e;
    logic [SUM_W-1:0] mag_e;
    logic [SUM_W-1:0] p_sum;
    logic [SUM_W-1:0] size_q;
    logic [POS_W-1:0] limit_q;
    logic             under;
    logic [pma_pkg::PIX_W-1:0] set_int;

    // Clamp to the delta limit and fold to a magnitude.
    always_comb
    begin
        priority if (delta > LIM_S || delta < -LIM_S)
        begin
            a_next = A_W'(DELTA_LIMIT);
        end
        else if (delta[pma_pkg::DELTA_W-1])
        begin
            a_next = A_W'(-delta);
        end
        else
        begin
            a_next = A_W'(delta);
        end
    end

    // Every curve segment has the form base + round((a - base) * k).
    always_comb
    begin
        a_m  = M_W'(a_reg);
        a_q  = {a_m, {FRAC_BITS{1'b0}}};
        base = B_ZERO;
        k    = K_ONE;
        unique case (accel)
            pma_pkg::ACCEL_LOW:
            begin
                if (a_m > M_W'(2))
                begin
                    base = B_TWO;
                    k    = K_13;
                end
            end
            pma_pkg::ACCEL_MED:
            begin
                priority if (a_m > M_W'(3))
                begin
                    base = B_THREE;
                    k    = K_18;
                end
                else if (a_m >= M_W'(2))
                begin
                    base = B_ONE_HALF;
                    k    = K_14;
                end
            end
            pma_pkg::ACCEL_HIGH:
            begin
                priority if (a_m > M_W'(5))
                begin
                    base = B_FIVE;
                    k    = K_30;
                end
                else if (a_m > M_W'(2))
                begin
                    base = B_TWO;
                    k    = K_20;
                end
                else
                begin
                    k    = K_12;
                end
            end
            default:
            begin
                base = B_ZERO;
                k    = K_ONE;
            end
        endcase
        off  = a_q - base;
        prod = PROD_W'(off) * PROD_W'(k);
        rnd  = prod + PROD_W'(HALF_I);
    end

    assign prod2 = P2_W'(q_reg) * P2_W'(speed_q);
    assign rnd2  = prod2 + P2_W'(HALF_I);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg   <= a_next;
            neg_reg <= delta[pma_pkg::DELTA_W-1];
        end
        if (ctl.curve)
        begin
            q_reg <= Q_W'(base) + Q_W'(rnd >> FRAC_BITS);
        end
        if (ctl.scale)
        begin
            mag_reg <= MAG_W'(rnd2 >> FRAC_BITS);
        end
    end

    // Advance and clamp to [0, size - 1] in whole pixels at the top end.
    always_comb
    begin
        pos_e   = SUM_W'(pos);
        mag_e   = SUM_W'(mag_reg);
        size_q  = SUM_W'({size, {FRAC_BITS{1'b0}}});
        limit_q = {pma_pkg::PIX_W'(size - pma_pkg::SIZE_W'(1)), {FRAC_BITS{1'b0}}};
        under   = neg_reg && (mag_e > pos_e);
        p_sum   = neg_reg ? (pos_e - mag_e) : (pos_e + mag_e);
        priority if (under)
        begin
            pos_moved = '0;
        end
        else if (p_sum >= size_q)
        begin
            pos_moved = limit_q;
        end
        else
        begin
            pos_moved = POS_W'(p_sum);
        end
    end

    // Absolute position request, clamped to the screen.
    always_comb
    begin
        priority if (set_v[pma_pkg::SET_W-1])
        begin
            set_int = '0;
        end
        else if (set_v[pma_pkg::SIZE_W-1:0] >= size)
        begin
            set_int = pma_pkg::PIX_W'(size - pma_pkg::SIZE_W'(1));
        end
        else
        begin
            set_int = set_v[pma_pkg::PIX_W-1:0];
        end
        pos_set = {set_int, {FRAC_BITS{1'b0}}};
    end

    // SQ_W documents the span of the scaled size compare.
    if (SQ_W > SUM_W)
    begin : g_width_guard
        $error("pma_lane: sum width too narrow for scaled screen size");
    end

endmodule

`default_nettype wire

// ----- rtl/core/pma_merge.sv -----
`default_nettype none

// Joins both axes: button edge, double-click test and the press record.
module pma_merge #(
    parameter int CLICK_RADIUS = 5
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire pma_pkg::merge_ctl_t             ctl,
    input  wire logic [pma_pkg::BTN_W-1:0]       buttons,
    input  wire logic [pma_pkg::TIME_W-1:0]      time_ms,
    input  wire logic [pma_pkg::WINDOW_W-1:0]    window,
    input  wire logic [pma_pkg::PIX_W-1:0]       cur_x,
    input  wire logic [pma_pkg::PIX_W-1:0]       cur_y,
    output pma_pkg::merge_res_t                  res
);

    logic [pma_pkg::BTN_W-1:0]  prev_buttons_reg;
    logic [pma_pkg::TIME_W-1:0] last_time_reg;
    logic [pma_pkg::PIX_W-1:0]  last_x_reg;
    logic [pma_pkg::PIX_W-1:0]  last_y_reg;

    logic                       motion;
    logic                       pressed;
    logic [pma_pkg::TIME_W-1:0] tdiff;
    logic [pma_pkg::PIX_W-1:0]  dx;
    logic [pma_pkg::PIX_W-1:0]  dy;
    logic                       near;

    always_comb
    begin
        motion  = !ctl.op_set && !ctl.lock;
        pressed = motion && buttons[0] && !prev_buttons_reg[0];
        tdiff   = time_ms - last_time_reg;
        dx      = (cur_x >= last_x_reg) ? (cur_x - last_x_reg) : (last_x_reg - cur_x);
        dy      = (cur_y >= last_y_reg) ? (cur_y - last_y_reg) : (last_y_reg - cur_y);
        near    = (dx < pma_pkg::PIX_W'(CLICK_RADIUS)) && (dy < pma_pkg::PIX_W'(CLICK_RADIUS));

        res.held_buttons = motion ? buttons : prev_buttons_reg;
        res.left_pressed = pressed;
        res.double_click = pressed && near
                           && (tdiff < pma_pkg::TIME_W'(window));
        res.was_ignored  = !ctl.op_set && ctl.lock;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_buttons_reg <= '0;
            last_time_reg    <= '0;
            last_x_reg       <= '0;
            last_y_reg       <= '0;
        end
        else if (ctl.commit && motion)
        begin
            prev_buttons_reg <= buttons;
            if (pressed)
            begin
                last_time_reg <= time_ms;
                last_x_reg    <= cur_x;
                last_y_reg    <= cur_y;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pointer_motion_accelerator.sv -----
// Pointer motion accelerator.
// Input beats on s_* carry one mouse report each: s_tuser is the op (0 motion,
// 1 set absolute position) and s_tdata holds the deltas, buttons, timestamp
// and requested position. Every input beat yields exactly one output beat on
// m_* with the integer cursor, the held buttons and the press, double-click
// and ignored flags. Settings are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while the block is idle, which the block
// itself does not enforce; writes take effect at the next clock edge.
// An item goes through four steps: curve (one multiply per axis), speed scale
// (one multiply per axis), position advance and clamp, then the merge stage
// that evaluates the buttons and loads the output register. The x and y lanes
// run side by side. A new beat is taken in the same cycle the previous result
// is loaded, so the block takes no new beat before it is through with the last.
// When the receiver stalls, the finished result waits in the output register
// and the block holds its final step, taking no new beat until the register
// frees. Reset clears the handshake, loads the default settings, centers the
// cursor on a 1920 by 1080 screen and clears the button and press record.
`default_nettype none

module pointer_motion_accelerator #(
    parameter int FRAC_BITS    = 8,
    parameter int DELTA_LIMIT  = 50,
    parameter int CLICK_RADIUS = 5
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pma_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pma_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // delta_x[15:0], delta_y[31:16], button_bits[39:32], time_ms[71:40],
    // set_x[86:72], set_y[101:87], zero fill above
    input  wire logic [pma_pkg::S_TDATA_W-1:0]     s_tdata,
    // op
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // cursor_x[12:0], cursor_y[25:13], held_buttons[33:26], left_pressed[34],
    // double_click[35], was_ignored[36], zero fill above
    output logic [pma_pkg::M_TDATA_W-1:0]          m_tdata
);

    localparam int POS_W   = pma_pkg::PIX_W + FRAC_BITS;
    localparam int SPEED_W = FRAC_BITS + 3;
    localparam int PCT     = 100;
    localparam int PCT_H   = PCT / 2;

    localparam logic [SPEED_W-1:0] SPEED_Q [pma_pkg::SPEED_LEVELS] = '{
        SPEED_W'(((pma_pkg::SPEED_HUNDREDTHS[0] << FRAC_BITS) + PCT_H) / PCT),
        SPEED_W'(((pma_pkg::SPEED_HUNDREDTHS[1] << FRAC_BITS) + PCT_H) / PCT),
        SPEED_W'(((pma_pkg::SPEED_HUNDREDTHS[2] << FRAC_BITS) + PCT_H) / PCT),
        SPEED_W'(((pma_pkg::SPEED_HUNDREDTHS[3] << FRAC_BITS) + PCT_H) / PCT),
        SPEED_W'(((pma_pkg::SPEED_HUNDREDTHS[4] << FRAC_BITS) + PCT_H) / PCT),
        SPEED_W'(((pma_pkg::SPEED_HUNDREDTHS[5] << FRAC_BITS) + PCT_H) / PCT),
        SPEED_W'(((pma_pkg::SPEED_HUNDREDTHS[6] << FRAC_BITS) + PCT_H) / PCT),
        SPEED_W'(((pma_pkg::SPEED_HUNDREDTHS[7] << FRAC_BITS) + PCT_H) / PCT),
        SPEED_W'(((pma_pkg::SPEED_HUNDREDTHS[8] << FRAC_BITS) + PCT_H) / PCT),
        SPEED_W'(((pma_pkg::SPEED_HUNDREDTHS[9] << FRAC_BITS) + PCT_H) / PCT)
    };

    localparam logic [POS_W-1:0] POS_RST_X =
        POS_W'(pma_pkg::RESET_WIDTH / 2) << FRAC_BITS;
    localparam logic [POS_W-1:0] POS_RST_Y =
        POS_W'(pma_pkg::RESET_HEIGHT / 2) << FRAC_BITS;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CURVE = 5'b00010,
        ST_SCALE = 5'b00100,
        ST_MOVE  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Settings.
    logic [pma_pkg::SIZE_W-1:0]     width_reg;
    logic [pma_pkg::SIZE_W-1:0]     height_reg;
    logic [pma_pkg::SPEED_IDX_W-1:0] speed_reg;
    pma_pkg::accel_t                accel_reg;
    logic [pma_pkg::WINDOW_W-1:0]   window_reg;
    logic                           lock_reg;

    // Item held while it is worked on.
    logic                              op_reg;
    logic [pma_pkg::BTN_W-1:0]         buttons_reg;
    logic [pma_pkg::TIME_W-1:0]        time_reg;
    logic signed [pma_pkg::SET_W-1:0]  set_x_reg;
    logic signed [pma_pkg::SET_W-1:0]  set_y_reg;

    // Position state and the candidate computed for the current item.
    logic [POS_W-1:0] pos_x_reg;
    logic [POS_W-1:0] pos_y_reg;
    logic [POS_W-1:0] new_x_reg;
    logic [POS_W-1:0] new_y_reg;

    logic                           m_tvalid_reg;
    logic [pma_pkg::M_TDATA_W-1:0]  m_tdata_reg;

    logic                           out_free;
    logic                           accept;
    logic                           commit;
    logic [pma_pkg::SIZE_W-1:0]     width_eff;
    logic [pma_pkg::SIZE_W-1:0]     height_eff;
    logic [pma_pkg::SPEED_IDX_W-1:0] speed_idx;
    logic [SPEED_W-1:0]             speed_q;
    logic [POS_W-1:0]               moved_x;
    logic [POS_W-1:0]               moved_y;
    logic [POS_W-1:0]               setp_x;
    logic [POS_W-1:0]               setp_y;
    pma_pkg::lane_ctl_t             lane_ctl;
    pma_pkg::merge_ctl_t            merge_ctl;
    pma_pkg::merge_res_t            merge_res;

    // Handshake. A new beat is taken when idle, or in the final step as the
    // finished result moves into the output register.
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == ST_EMIT) && out_free;
    assign s_tready = (state_reg == ST_IDLE) || commit;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:  state_next = accept ? ST_CURVE : ST_IDLE;
            ST_CURVE: state_next = ST_SCALE;
            ST_SCALE: state_next = ST_MOVE;
            ST_MOVE:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                priority if (!out_free)
                begin
                    state_next = ST_EMIT;
                end
                else if (accept)
                begin
                    state_next = ST_CURVE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= pma_pkg::SIZE_W'(pma_pkg::RESET_WIDTH);
            height_reg <= pma_pkg::SIZE_W'(pma_pkg::RESET_HEIGHT);
            speed_reg  <= pma_pkg::SPEED_IDX_W'(pma_pkg::RESET_SPEED);
            accel_reg  <= pma_pkg::ACCEL_MED;
            window_reg <= pma_pkg::WINDOW_W'(pma_pkg::RESET_WINDOW);
            lock_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pma_pkg::CFG_SCREEN_WIDTH:  width_reg  <= cfg_wdata[pma_pkg::SIZE_W-1:0];
                pma_pkg::CFG_SCREEN_HEIGHT: height_reg <= cfg_wdata[pma_pkg::SIZE_W-1:0];
                pma_pkg::CFG_SPEED_LEVEL:   speed_reg  <= cfg_wdata[pma_pkg::SPEED_IDX_W-1:0];
                pma_pkg::CFG_ACCEL_LEVEL:   accel_reg  <= pma_pkg::accel_t'(cfg_wdata[1:0]);
                pma_pkg::CFG_CLICK_WINDOW:  window_reg <= cfg_wdata;
                pma_pkg::CFG_MOTION_LOCK:   lock_reg   <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Out-of-range sizes and speed levels saturate to the nearest legal one.
    always_comb
    begin
        priority if (width_reg == '0)
        begin
            width_eff = pma_pkg::SIZE_W'(1);
        end
        else if (width_reg > pma_pkg::SIZE_W'(pma_pkg::MAX_SCREEN))
        begin
            width_eff = pma_pkg::SIZE_W'(pma_pkg::MAX_SCREEN);
        end
        else
        begin
            width_eff = width_reg;
        end

        priority if (height_reg == '0)
        begin
            height_eff = pma_pkg::SIZE_W'(1);
        end
        else if (height_reg > pma_pkg::SIZE_W'(pma_pkg::MAX_SCREEN))
        begin
            height_eff = pma_pkg::SIZE_W'(pma_pkg::MAX_SCREEN);
        end
        else
        begin
            height_eff = height_reg;
        end

        priority if (speed_reg == '0)
        begin
            speed_idx = '0;
        end
        else if (speed_reg > pma_pkg::SPEED_IDX_W'(pma_pkg::SPEED_LEVELS))
        begin
            speed_idx = pma_pkg::SPEED_IDX_W'(pma_pkg::SPEED_LEVELS - 1);
        end
        else
        begin
            speed_idx = speed_reg - pma_pkg::SPEED_IDX_W'(1);
        end
        speed_q = SPEED_Q[speed_idx];
    end

    // Capture the item fields that the later steps need.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= s_tuser;
            buttons_reg <= s_tdata[39:32];
            time_reg    <= s_tdata[71:40];
            set_x_reg   <= s_tdata[86:72];
            set_y_reg   <= s_tdata[101:87];
        end
    end

    always_comb
    begin
        lane_ctl.load  = accept;
        lane_ctl.curve = (state_reg == ST_CURVE);
        lane_ctl.scale = (state_reg == ST_SCALE);
    end

    pma_lane #(
        .FRAC_BITS   (FRAC_BITS),
        .DELTA_LIMIT (DELTA_LIMIT)
    ) u_lane_x (
        .clk       (clk),
        .ctl       (lane_ctl),
        .delta     (s_tdata[15:0]),
        .accel     (accel_reg),
        .speed_q   (speed_q),
        .pos       (pos_x_reg),
        .size      (width_eff),
        .set_v     (set_x_reg),
        .pos_moved (moved_x),
        .pos_set   (setp_x)
    );

    pma_lane #(
        .FRAC_BITS   (FRAC_BITS),
        .DELTA_LIMIT (DELTA_LIMIT)
    ) u_lane_y (
        .clk       (clk),
        .ctl       (lane_ctl),
        .delta     (s_tdata[31:16]),
        .accel     (accel_reg),
        .speed_q   (speed_q),
        .pos       (pos_y_reg),
        .size      (height_eff),
        .set_v     (set_y_reg),
        .pos_moved (moved_y),
        .pos_set   (setp_y)
    );

    // Pick the new position: a set request wins over the lock, a locked
    // motion report keeps the stored position.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MOVE)
        begin
            priority if (op_reg)
            begin
                new_x_reg <= setp_x;
                new_y_reg <= setp_y;
            end
            else if (lock_reg)
            begin
                new_x_reg <= pos_x_reg;
                new_y_reg <= pos_y_reg;
            end
            else
            begin
                new_x_reg <= moved_x;
                new_y_reg <= moved_y;
            end
        end
    end

    always_comb
    begin
        merge_ctl.commit = commit;
        merge_ctl.op_set = op_reg;
        merge_ctl.lock   = lock_reg;
    end

    pma_merge #(
        .CLICK_RADIUS (CLICK_RADIUS)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (merge_ctl),
        .buttons (buttons_reg),
        .time_ms (time_reg),
        .window  (window_reg),
        .cur_x   (new_x_reg[POS_W-1:FRAC_BITS]),
        .cur_y   (new_y_reg[POS_W-1:FRAC_BITS]),
        .res     (merge_res)
    );

    // Position state is written as the result leaves.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= POS_RST_X;
            pos_y_reg <= POS_RST_Y;
        end
        else if (commit)
        begin
            pos_x_reg <= new_x_reg;
            pos_y_reg <= new_y_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (commit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            m_tdata_reg <= {3'b000,
                            merge_res.was_ignored,
                            merge_res.double_click,
                            merge_res.left_pressed,
                            merge_res.held_buttons,
                            new_y_reg[POS_W-1:FRAC_BITS],
                            new_x_reg[POS_W-1:FRAC_BITS]};
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pma_checker.sv -----
`default_nettype none

`include "pointer_motion_accelerator_macros.svh"

// Port-level checks for the pointer motion block.
module pma_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [pma_pkg::M_TDATA_W-1:0]  m_tdata
);

    // An ignored report never carries a press or a double click.
    `PMA_ASSERT_IMP(a_ignored_quiet, m_tvalid && m_tdata[36], !m_tdata[34] && !m_tdata[35], "ignored beat flags a press")

    // A double click is always a press as well.
    `PMA_ASSERT_IMP(a_dbl_is_press, m_tvalid && m_tdata[35], m_tdata[34], "double click without press")

    // One report at a time: the cycle after an input beat the block is busy.
    `PMA_ASSERT_NXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready, "beat taken back to back")

    // A stalled result holds still.
    `PMA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind pointer_motion_accelerator pma_checker u_pma_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- tb/tb_pointer_motion_accelerator.sv -----
// Stand-alone bench for the pointer motion accelerator.
//
// Mouse reports go into the block through a queue that a clocked driver
// empties onto the s_* stream. A monitor on the rising edge sees every
// accepted report and runs a bit-exact copy of the cursor tracker in this
// file. That tracker models the delta clamp, the four acceleration curves,
// the speed table, the screen clamp and the press and double-click record.
// Its forecast is compared field by field with each result beat on the m_*
// stream. Settings change only between phases, while nothing is in flight.
module tb_pointer_motion_accelerator;
    timeunit 1ns;
    timeprecision 1ps;

    import pma_pkg::*;

    // Stream op codes (s_tuser).
    localparam bit OP_MOTION = 1'b0;
    localparam bit OP_SET    = 1'b1;

    // Fixed-point format of positions and curve values.
    localparam int    FRAC_Q       = 8;
    localparam longint ONE_Q       = 64'sd256;
    localparam longint HALF_Q      = 64'sd128;
    localparam int    STEP_LIMIT   = 50;
    localparam int    PRESS_RADIUS = 5;

    // Run shape.
    localparam int DIRECTED_PHASES = 4;
    localparam int RANDOM_PHASES   = 14;
    localparam int PHASE_REPORTS   = 80;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int STALL_LIMIT     = 4000;

    // One mouse report as it is packed into s_tdata and s_tuser.
    typedef struct {
        bit               op;
        bit signed [15:0] dx;
        bit signed [15:0] dy;
        bit [7:0]         btn;
        bit [31:0]        tms;
        bit signed [14:0] sx;
        bit signed [14:0] sy;
    } report_t;

    // One cursor result as it is unpacked from m_tdata.
    typedef struct {
        bit [12:0] cx;
        bit [12:0] cy;
        bit [7:0]  held;
        bit        press;
        bit        dbl;
        bit        ign;
    } cursor_res_t;

    bit   clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // delta_x, delta_y, button_bits, time_ms, set_x, set_y, zero fill above
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    // op
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // cursor_x, cursor_y, held_buttons, left_pressed, double_click,
    // was_ignored, zero fill above
    logic [M_TDATA_W-1:0]  m_tdata;

    pointer_motion_accelerator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 4 ns clock period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the settings and of the tracker state.
    // ------------------------------------------------------------------
    bit [13:0] cfg_width  = 14'(RESET_WIDTH);
    bit [13:0] cfg_height = 14'(RESET_HEIGHT);
    bit [3:0]  cfg_speed  = 4'(RESET_SPEED);
    accel_t    cfg_accel  = ACCEL_MED;
    bit [15:0] cfg_window = 16'(RESET_WINDOW);
    bit        cfg_lock   = 1'b0;

    // Reset centers the cursor with a zero fraction.
    longint    pos_x = longint'(RESET_WIDTH / 2) <<< FRAC_Q;
    longint    pos_y = longint'(RESET_HEIGHT / 2) <<< FRAC_Q;
    bit [7:0]  held_btn = '0;
    bit [31:0] press_time = '0;
    bit [12:0] press_x = '0;
    bit [12:0] press_y = '0;

    // Traffic bookkeeping.
    report_t     queued_reports[$];
    cursor_res_t awaited_cursors[$];
    report_t     on_bus;
    int unsigned reports_sent  = 0;
    int unsigned reports_taken = 0;
    int unsigned cursors_seen  = 0;
    int unsigned errors        = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned hold_reqs     = 0;
    bit          calm          = 1'b0;

    // Generator state for well-formed report sequences.
    bit [7:0]  btn_now  = '0;
    bit [31:0] clock_ms = 32'd1000;

    // ------------------------------------------------------------------
    // Cursor tracker.
    // ------------------------------------------------------------------

    // A fraction num/den rounded to the nearest 1/256, halves up.
    function automatic longint to_q(longint num, longint den);
        return ((num <<< FRAC_Q) + den / 2) / den;
    endfunction

    // Product of a Q8 offset and a Q8 slope, rounded back to Q8.
    function automatic longint round_q(longint off, longint k);
        return (off * k + HALF_Q) >>> FRAC_Q;
    endfunction

    function automatic longint speed_pct(int lvl);
        case (lvl)
            1:       return 25;
            2:       return 45;
            3:       return 65;
            4:       return 85;
            5:       return 100;
            6:       return 140;
            7:       return 180;
            8:       return 250;
            9:       return 320;
            default: return 400;
        endcase
    endfunction

    // Acceleration curve on the integer magnitude of a clamped delta.
    function automatic longint bend(longint a);
        case (cfg_accel)
            ACCEL_LOW:
            begin
                if (a > 2)
                    return 2 * ONE_Q + round_q((a <<< FRAC_Q) - 2 * ONE_Q, to_q(13, 10));
            end
            ACCEL_MED:
            begin
                if (a > 3)
                    return 3 * ONE_Q + round_q((a <<< FRAC_Q) - 3 * ONE_Q, to_q(18, 10));
                if (a >= 2)
                    return 3 * HALF_Q + round_q((a <<< FRAC_Q) - 3 * HALF_Q, to_q(14, 10));
            end
            ACCEL_HIGH:
            begin
                if (a > 5)
                    return 5 * ONE_Q + round_q((a <<< FRAC_Q) - 5 * ONE_Q, to_q(3, 1));
                if (a > 2)
                    return 2 * ONE_Q + round_q((a <<< FRAC_Q) - 2 * ONE_Q, to_q(2, 1));
                return a * to_q(12, 10);
            end
            default: ;
        endcase
        return a <<< FRAC_Q;
    endfunction

    // Signed Q8 movement for one raw delta. The sign is applied last, so
    // the curve and the speed scaling are symmetric.
    function automatic longint step_q(bit signed [15:0] raw);
        longint d;
        longint mag;
        int     lvl;
        d = raw;
        if (d > STEP_LIMIT)
            d = STEP_LIMIT;
        if (d < -STEP_LIMIT)
            d = -STEP_LIMIT;
        // Speed levels outside 1..10 saturate.
        lvl = cfg_speed;
        if (lvl < 1)
            lvl = 1;
        if (lvl > 10)
            lvl = 10;
        mag = (bend(d < 0 ? -d : d) * to_q(speed_pct(lvl), 100) + HALF_Q) >>> FRAC_Q;
        return d < 0 ? -mag : mag;
    endfunction

    // A size of zero acts as one, anything above the maximum as the maximum.
    function automatic longint fit_size(bit [13:0] s);
        if (s == 0)
            return 1;
        if (s > MAX_SCREEN)
            return MAX_SCREEN;
        return s;
    endfunction

    // Motion clamp: past the edge lands on the last pixel with no fraction,
    // while a fraction inside the last pixel survives.
    function automatic longint advance(longint pos, longint amt, longint size);
        longint p;
        p = pos + amt;
        if (p < 0)
            return 0;
        if (p >= (size <<< FRAC_Q))
            return (size - 1) <<< FRAC_Q;
        return p;
    endfunction

    function automatic longint place_clamp(longint v, longint size);
        if (v < 0)
            return 0;
        if (v >= size)
            return size - 1;
        return v;
    endfunction

    function automatic int unsigned gap_px(int unsigned a, int unsigned b);
        return a > b ? a - b : b - a;
    endfunction

    // Applies one report to the shadow state and returns the cursor beat
    // that the block has to produce for it.
    function automatic cursor_res_t track_report(report_t r);
        cursor_res_t res;
        longint      w;
        longint      h;
        int unsigned px;
        int unsigned py;
        bit [31:0]   since;
        res = '{default: 0};
        w = fit_size(cfg_width);
        h = fit_size(cfg_height);
        if (r.op == OP_SET)
        begin
            // Honored under the lock; the button record stays as it is.
            pos_x = place_clamp(r.sx, w) <<< FRAC_Q;
            pos_y = place_clamp(r.sy, h) <<< FRAC_Q;
        end
        else if (cfg_lock)
        begin
            res.ign = 1'b1;
        end
        else
        begin
            pos_x = advance(pos_x, step_q(r.dx), w);
            pos_y = advance(pos_y, step_q(r.dy), h);
            px = int'(pos_x >>> FRAC_Q);
            py = int'(pos_y >>> FRAC_Q);
            if (r.btn[0] && !held_btn[0])
            begin
                res.press = 1'b1;
                // Elapsed time wraps with the 32-bit timestamp.
                since = r.tms - press_time;
                if (since < cfg_window && gap_px(px, press_x) < PRESS_RADIUS
                    && gap_px(py, press_y) < PRESS_RADIUS)
                    res.dbl = 1'b1;
                press_time = r.tms;
                press_x = px[12:0];
                press_y = py[12:0];
            end
            held_btn = r.btn;
        end
        res.cx = 13'(pos_x >>> FRAC_Q);
        res.cy = 13'(pos_y >>> FRAC_Q);
        res.held = held_btn;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    function automatic report_t mouse_move(int dx, int dy, bit [7:0] btn, bit [31:0] tms);
        report_t r;
        r = '{default: 0};
        r.op = OP_MOTION;
        r.dx = 16'(dx);
        r.dy = 16'(dy);
        r.btn = btn;
        r.tms = tms;
        return r;
    endfunction

    function automatic report_t place_at(int x, int y);
        report_t r;
        r = '{default: 0};
        r.op = OP_SET;
        r.sx = 15'(x);
        r.sy = 15'(y);
        return r;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (calm || k < 55)
            return 0;
        if (k < 88)
            return $urandom_range(1, 3);
        if (k < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit signed [15:0] pick_delta();
        int k;
        k = $urandom_range(0, 99);
        if (k < 30)
            return 16'($urandom_range(0, 6) - 3);
        if (k < 70)
            return 16'($urandom_range(0, 120) - 60);
        if (k < 85)
            return 16'($urandom);
        case ($urandom_range(0, 6))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sd50;
            3:       return -16'sd50;
            4:       return 16'sd51;
            5:       return -16'sd51;
            default: return 16'sd0;
        endcase
    endfunction

    function automatic bit signed [14:0] pick_place();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60)
            return 15'($urandom_range(0, 8300));
        if (k < 80)
            return 15'($urandom);
        case ($urandom_range(0, 3))
            0:       return 15'sh4000;
            1:       return 15'sh3FFF;
            2:       return -15'sd1;
            default: return 15'sd0;
        endcase
    endfunction

    // Mostly a plausible mouse: small moves, the left button going up and
    // down, time running forward. The rest is jumps in time and wild deltas.
    function automatic report_t random_report();
        report_t r;
        int      k;
        r = '{default: 0};
        r.op = ($urandom_range(0, 99) < 10) ? OP_SET : OP_MOTION;
        r.dx = pick_delta();
        r.dy = pick_delta();
        if ($urandom_range(0, 99) < 45)
            btn_now[0] = ~btn_now[0];
        if ($urandom_range(0, 9) == 0)
            btn_now[7:1] = 7'($urandom);
        r.btn = btn_now;
        k = $urandom_range(0, 99);
        if (k < 80)
            clock_ms = clock_ms + $urandom_range(0, 250);
        else if (k < 92)
            clock_ms = clock_ms + $urandom_range(250, 3000);
        else if (k < 97)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms - $urandom_range(0, 100);
        r.tms = clock_ms;
        r.sx = pick_place();
        r.sy = pick_place();
        return r;
    endfunction

    // Writes one setting and mirrors it in the shadow copy. Called only
    // while nothing is in flight, so the shadow may change at once.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SCREEN_WIDTH:  cfg_width = val[13:0];
            CFG_SCREEN_HEIGHT: cfg_height = val[13:0];
            CFG_SPEED_LEVEL:   cfg_speed = val[3:0];
            CFG_ACCEL_LEVEL:   cfg_accel = accel_t'(val[1:0]);
            CFG_CLICK_WINDOW:  cfg_window = val[15:0];
            CFG_MOTION_LOCK:   cfg_lock = val[0];
            default: ;
        endcase
    endtask

    // Waits until every queued report went in and every result came out,
    // then lets the pipeline run dry before it returns.
    task automatic settle();
        @(negedge clk);
        while (queued_reports.size() != 0 || reports_sent != reports_taken
               || cursors_seen != reports_taken)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Report driver: one beat on the bus until it is taken, then an
    // optional idle gap before the next one.
    // ------------------------------------------------------------------
    int tx_gap = 0;

    always @(negedge clk)
    begin : report_driver
        report_t nxt;
        if (rst_n && reports_sent == reports_taken)
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end
            else if (queued_reports.size() > 0)
            begin
                nxt = queued_reports.pop_front();
                on_bus = nxt;
                s_tdata <= {2'b00, nxt.sy, nxt.sx, nxt.tms, nxt.btn, nxt.dy, nxt.dx};
                s_tuser <= nxt.op;
                s_tvalid <= 1'b1;
                reports_sent++;
                tx_gap = pick_gap();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random back-pressure, plus a long hold on request
    // so that the block fills up and has to stall its input side.
    // ------------------------------------------------------------------
    int          rx_gap = 0;
    int          hold_left = 0;
    int unsigned hold_done = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_reqs != hold_done)
        begin
            hold_done = hold_reqs;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_gap = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks result beats against the forecast, records accepted
    // reports, and ends the run when the bus stays quiet for too long.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : beat_monitor
        cursor_res_t want;
        bit          moved;
        moved = 1'b0;
        if (m_tvalid && m_tready)
        begin
            moved = 1'b1;
            cursors_seen++;
            if (awaited_cursors.size() == 0)
            begin
                $error("result beat with nothing awaited: m_tdata=%h", m_tdata);
                errors++;
            end
            else
            begin
                want = awaited_cursors.pop_front();
                if (m_tdata[12:0] !== want.cx)
                begin
                    $error("cursor_x: expected %0d, got %0d", want.cx, m_tdata[12:0]);
                    errors++;
                end
                if (m_tdata[25:13] !== want.cy)
                begin
                    $error("cursor_y: expected %0d, got %0d", want.cy, m_tdata[25:13]);
                    errors++;
                end
                if (m_tdata[33:26] !== want.held)
                begin
                    $error("held_buttons: expected %h, got %h", want.held, m_tdata[33:26]);
                    errors++;
                end
                if (m_tdata[34] !== want.press)
                begin
                    $error("left_pressed: expected %0d, got %0d", want.press, m_tdata[34]);
                    errors++;
                end
                if (m_tdata[35] !== want.dbl)
                begin
                    $error("double_click: expected %0d, got %0d", want.dbl, m_tdata[35]);
                    errors++;
                end
                if (m_tdata[36] !== want.ign)
                begin
                    $error("was_ignored: expected %0d, got %0d", want.ign, m_tdata[36]);
                    errors++;
                end
            end
        end
        if (s_tvalid && s_tready)
        begin
            moved = 1'b1;
            reports_taken++;
            awaited_cursors.push_back(track_report(on_bus));
        end
        if (!rst_n || moved)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_pointer_motion_accelerator: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned spd;
        int unsigned acc;
        int unsigned win;
        int unsigned lck;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        // Default settings. The first press after reset is measured against
        // the reset record (time 0 at the origin), so parking the cursor
        // next to the origin makes it a double click.
        queued_reports.push_back(place_at(2, 3));
        queued_reports.push_back(mouse_move(0, 0, 8'h01, 32'd10));
        queued_reports.push_back(mouse_move(0, 0, 8'h00, 32'd20));
        // Press just below the timestamp wrap, then one just after it.
        queued_reports.push_back(mouse_move(1, -1, 8'h01, 32'hFFFF_FFF0));
        queued_reports.push_back(mouse_move(0, 0, 8'h00, 32'h0000_0005));
        queued_reports.push_back(mouse_move(0, 0, 8'h01, 32'h0000_0010));
        // Extreme raw deltas, the clamp limit and one past it.
        queued_reports.push_back(mouse_move(32767, -32768, 8'hFE, 32'd30));
        queued_reports.push_back(mouse_move(50, -50, 8'h00, 32'd40));
        queued_reports.push_back(mouse_move(-51, 51, 8'hFF, 32'd50));
        // Each segment of the medium curve.
        queued_reports.push_back(mouse_move(2, -3, 8'h00, 32'd60));
        queued_reports.push_back(mouse_move(4, -6, 8'h00, 32'd70));
        // Requested positions beyond the screen in both directions.
        queued_reports.push_back(place_at(-16384, 16383));
        queued_reports.push_back(place_at(16383, -16384));
        settle();

        // Slowest speed, no curve: quarter-pixel steps into the last pixel
        // keep their fraction, a step past the edge drops it.
        set_reg(CFG_SCREEN_WIDTH, 100);
        set_reg(CFG_SCREEN_HEIGHT, 50);
        set_reg(CFG_SPEED_LEVEL, 1);
        set_reg(CFG_ACCEL_LEVEL, ACCEL_OFF);
        queued_reports.push_back(place_at(99, 49));
        queued_reports.push_back(mouse_move(1, 1, 8'h00, 32'd80));
        queued_reports.push_back(mouse_move(3, 3, 8'h00, 32'd90));
        settle();

        // Locked, with a zero width and an oversize height. Motion is
        // dropped and reports the stored position even though it now lies
        // off screen; a set item still goes through and is clamped.
        set_reg(CFG_SCREEN_WIDTH, 0);
        set_reg(CFG_SCREEN_HEIGHT, 16383);
        set_reg(CFG_SPEED_LEVEL, 0);
        set_reg(CFG_ACCEL_LEVEL, ACCEL_LOW);
        set_reg(CFG_MOTION_LOCK, 1);
        queued_reports.push_back(mouse_move(10, 10, 8'h01, 32'd100));
        queued_reports.push_back(place_at(500, 500));
        queued_reports.push_back(mouse_move(-5, 5, 8'h00, 32'd110));
        settle();

        // Unlocked again: oversize speed, high curve on all three segments,
        // and a zero click window that never allows a double click.
        set_reg(CFG_MOTION_LOCK, 0);
        set_reg(CFG_SCREEN_WIDTH, MAX_SCREEN);
        set_reg(CFG_SPEED_LEVEL, 15);
        set_reg(CFG_ACCEL_LEVEL, ACCEL_HIGH);
        set_reg(CFG_CLICK_WINDOW, 0);
        queued_reports.push_back(mouse_move(3, -3, 8'h01, 32'd120));
        queued_reports.push_back(mouse_move(6, 6, 8'h00, 32'd130));
        queued_reports.push_back(mouse_move(-1, -2, 8'h01, 32'd131));
        queued_reports.push_back(mouse_move(-32768, 32767, 8'h00, 32'd140));
        settle();

        // Random phases, each under its own settings. The first few pin
        // the extremes of the registers.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            w = ($urandom_range(0, 99) < 70) ? $urandom_range(16, 2560)
                                              : $urandom_range(0, 16383);
            h = ($urandom_range(0, 99) < 70) ? $urandom_range(16, 2560)
                                              : $urandom_range(0, 16383);
            spd = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10)
                                                : $urandom_range(0, 15);
            acc = $urandom_range(0, 3);
            win = ($urandom_range(0, 99) < 70) ? $urandom_range(50, 1500)
                                                : $urandom_range(0, 65535);
            lck = ($urandom_range(0, 99) < 15) ? 1 : 0;
            case (p)
                0:
                begin
                    w = MAX_SCREEN;
                    h = MAX_SCREEN;
                    spd = 10;
                    acc = ACCEL_HIGH;
                    win = 65535;
                    lck = 0;
                end
                1:
                begin
                    w = 1;
                    h = 1;
                    spd = 1;
                    acc = ACCEL_OFF;
                    win = 0;
                end
                2:
                begin
                    w = 16383;
                    h = 0;
                    spd = 0;
                    acc = ACCEL_MED;
                end
                3:       lck = 0;
                4:       spd = 15;
                default: ;
            endcase
            set_reg(CFG_SCREEN_WIDTH, w);
            set_reg(CFG_SCREEN_HEIGHT, h);
            set_reg(CFG_SPEED_LEVEL, spd);
            set_reg(CFG_ACCEL_LEVEL, acc);
            set_reg(CFG_CLICK_WINDOW, win);
            set_reg(CFG_MOTION_LOCK, lck);

            // Some phases run without any idling on either side.
            calm = (p == 6 || p == 10);
            // Back-pressure phase: the receiver holds off for a long time
            // while the whole phase is already waiting at the input.
            if (p == 3)
                hold_reqs++;
            for (int i = 0; i < PHASE_REPORTS; i++)
                queued_reports.push_back(random_report());
            settle();
        end

        if (errors == 0)
            $display("tb_pointer_motion_accelerator: done, clean");
        else
            $display("tb_pointer_motion_accelerator: done, errors");
        $finish;
    end

endmodule
